// ----- rtl/ctcc_pkg.sv -----
// Shared definitions for the card / tape / CPU character code converter.
// Holds the operation codes, the character constants and the tape-to-punch table.
// No dependencies.
package ctcc_pkg;

  // Conversion directions carried in the operation field
  typedef enum logic [2:0] {
    OP_TAPE_CPU  = 3'd0,
    OP_TAPE_CARD = 3'd1,
    OP_CPU_TAPE  = 3'd2,
    OP_CPU_CARD  = 3'd3,
    OP_CARD_TAPE = 3'd4,
    OP_CARD_CPU  = 3'd5
  } op_e;

  // Character constants of the 6-bit codes
  localparam logic [5:0] BCD_BLANK     = 6'h10;
  localparam logic [5:0] BCD_TAPE_ZERO = 6'h0A;
  localparam logic [5:0] BCD_CPU_ZERO  = 6'h00;
  localparam logic [5:0] BCD_ZONE_FLIP = 6'h20;

  // Card row that acts as a zone punch
  localparam logic [11:0] CARD_ROW_0 = 12'h200;

  // Canonical punch for each tape code
  localparam logic [11:0] PUNCH_OF_TAPE [64] = '{
    12'h082, 12'h001, 12'h002, 12'h004, 12'h008, 12'h010, 12'h020, 12'h040,
    12'h080, 12'h100, 12'h200, 12'h084, 12'h088, 12'h090, 12'h0A0, 12'h0C0,
    12'h000, 12'h201, 12'h202, 12'h204, 12'h208, 12'h210, 12'h220, 12'h240,
    12'h280, 12'h300, 12'h282, 12'h284, 12'h288, 12'h290, 12'h2A0, 12'h2C0,
    12'h400, 12'h401, 12'h402, 12'h404, 12'h408, 12'h410, 12'h420, 12'h440,
    12'h480, 12'h500, 12'h600, 12'h484, 12'h488, 12'h490, 12'h4A0, 12'h4C0,
    12'h800, 12'h801, 12'h802, 12'h804, 12'h808, 12'h810, 12'h820, 12'h840,
    12'h880, 12'h900, 12'hA00, 12'h884, 12'h888, 12'h890, 12'h8A0, 12'h8C0
  };

  // Tape to CPU: swap the zone bits when bit 4 is set, tape zero becomes CPU zero
  function automatic logic [5:0] tape_to_cpu(input logic [5:0] t);
    logic [5:0] z;
    z = t[4] ? (t ^ BCD_ZONE_FLIP) : t;
    return (z == BCD_TAPE_ZERO) ? BCD_CPU_ZERO : z;
  endfunction

  // CPU to tape: the same swap, CPU zero becomes tape zero
  function automatic logic [5:0] cpu_to_tape(input logic [5:0] c);
    logic [5:0] z;
    z = c[4] ? (c ^ BCD_ZONE_FLIP) : c;
    return (z == BCD_CPU_ZERO) ? BCD_TAPE_ZERO : z;
  endfunction

endpackage

// ----- rtl/card_tape_cpu_code_converter.sv -----
// Top level of the card / tape / CPU character code converter.
// Depends on ctcc_pkg and ctcc_card_dec.
//
// Usage:
//   The slave stream carries one character per transaction: tdata[2:0] is the
//   operation (0 tape->cpu, 1 tape->card, 2 cpu->tape, 3 cpu->card,
//   4 card->tape, 5 card->cpu), tdata[14:3] the source code. The master stream
//   returns one converted code per transaction in tdata[11:0]; BCD results sit
//   in bits 5:0 with the upper bits zero. Operations 6 and 7 return zero.
//   The result passes through the block's three-register pipeline (input
//   capture, conversion to tape code, final conversion) before tvalid rises
//   on the master side; the block takes one transaction every cycle while
//   the receiver keeps tready high.
//   Reset clears all stage valid bits, so the master side is idle after reset
//   and tready on the slave side is high.
//   When the receiver stalls, the last stage holds its result and ready
//   propagates back stage by stage: empty stages keep filling, so up to three
//   transactions are held before the slave side drops tready. Nothing is lost
//   or repeated.
module card_tape_cpu_code_converter (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Slave stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,  // [2:0] operation, [14:3] code_in, [15] zero
  // Master stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o   // [11:0] code_out, [15:12] zero
);
  import ctcc_pkg::*;

  logic        adv1, adv2, adv3;
  logic        v1_q, v2_q, v3_q;
  logic [2:0]  op1_q, op2_q;
  logic [11:0] code1_q;
  logic [5:0]  tape2_d, tape2_q;
  logic [11:0] code3_d, code3_q;
  logic [5:0]  card_tape;

  // Each stage moves when it is empty or the next one moves
  assign adv3 = !v3_q || m_axis_tready_i;
  assign adv2 = !v2_q || adv3;
  assign adv1 = !v1_q || adv2;
  assign s_axis_tready_o = adv1;

  // Stage 1: capture the transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (adv1) begin
      v1_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv1 && s_axis_tvalid_i) begin
      op1_q   <= s_axis_tdata_i[2:0];
      code1_q <= s_axis_tdata_i[14:3];
    end
  end

  // Stage 2: bring the source into tape code
  ctcc_card_dec u_card_dec (
    .card_i (code1_q),
    .tape_o (card_tape)
  );

  always_comb begin
    case (op1_q)
      OP_TAPE_CPU, OP_TAPE_CARD: tape2_d = code1_q[5:0];
      OP_CPU_TAPE, OP_CPU_CARD:  tape2_d = cpu_to_tape(code1_q[5:0]);
      OP_CARD_TAPE, OP_CARD_CPU: tape2_d = card_tape;
      default:                   tape2_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (adv2) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv2 && v1_q) begin
      op2_q   <= op1_q;
      tape2_q <= tape2_d;
    end
  end

  // Stage 3: convert the tape code to the target code
  always_comb begin
    case (op2_q)
      OP_TAPE_CPU, OP_CARD_CPU:  code3_d = {6'd0, tape_to_cpu(tape2_q)};
      OP_TAPE_CARD, OP_CPU_CARD: code3_d = PUNCH_OF_TAPE[tape2_q];
      OP_CPU_TAPE, OP_CARD_TAPE: code3_d = {6'd0, tape2_q};
      default:                   code3_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (adv3) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv3 && v2_q) begin
      code3_q <= code3_d;
    end
  end

  assign m_axis_tvalid_o = v3_q;
  assign m_axis_tdata_o  = {4'd0, code3_q};

  // An accepted transaction always lands in stage 1
  a_accept_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> v1_q)
    else $error("accepted transaction did not reach stage 1");

  // A stalled stage 1 keeps its transaction
  a_stage1_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v1_q && !adv2 |=> v1_q && $stable(code1_q) && $stable(op1_q))
    else $error("stage 1 lost its transaction under stall");

  // BCD results leave the upper rows clear
  a_bcd_upper_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv3 && v2_q && (op2_q == OP_TAPE_CPU || op2_q == OP_CARD_CPU ||
                     op2_q == OP_CPU_TAPE || op2_q == OP_CARD_TAPE)
    |=> code3_q[11:6] == 6'd0)
    else $error("BCD result has upper bits set");

  // CPU results never carry the tape zero code
  a_cpu_no_tape_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv3 && v2_q && (op2_q == OP_TAPE_CPU || op2_q == OP_CARD_CPU)
    |=> code3_q[5:0] != BCD_TAPE_ZERO)
    else $error("CPU result carries tape zero code");

endmodule

// ----- rtl/ctcc_card_dec.sv -----
// Card column to tape BCD decoder, purely combinational.
// Depends on ctcc_pkg for the character constants.
module ctcc_card_dec (
  input  logic [11:0] card_i, // rows 1-9 in bits 0-8, row 0 bit 9, row 11 bit 10, row 12 bit 11
  output logic [5:0]  tape_o
);
  import ctcc_pkg::*;

  logic [10:0] digit_mask;
  logic [1:0]  zone;
  logic [3:0]  digits;
  logic [5:0]  value;

  // Pick the highest zone punch; rows below it count as digits
  always_comb begin
    if (card_i[11]) begin
      zone       = 2'd3;
      digit_mask = 11'h7FF;
    end else if (card_i[10]) begin
      zone       = 2'd2;
      digit_mask = 11'h3FF;
    end else if (card_i[9]) begin
      zone       = 2'd1;
      digit_mask = 11'h1FF;
    end else begin
      zone       = 2'd0;
      digit_mask = 11'h3FF;
    end
  end

  // OR the row numbers of all punched digit rows, row 0 as 10 and row 11 as 11
  always_comb begin
    digits = '0;
    for (int i = 0; i < 11; i++) begin
      if (card_i[i] && digit_mask[i]) begin
        digits = digits | 4'(i + 1);
      end
    end
  end

  // Fold in the special columns
  always_comb begin
    value = {zone, digits};
    if (value == BCD_TAPE_ZERO) begin
      value = BCD_BLANK;
    end
    if (card_i == '0) begin
      tape_o = BCD_BLANK;
    end else if (card_i == CARD_ROW_0) begin
      tape_o = BCD_TAPE_ZERO;
    end else begin
      tape_o = value;
    end
  end

endmodule
